FILE: rtl/core/plob_pkg.sv
// Shared types and constants for the price level order book.
`default_nettype none
package plob_pkg;

   localparam int LevelsDefault = 512;
   localparam int PriceBitsDefault = 40;
   localparam int VolumeBitsDefault = 48;
   localparam int OrderBits = 16;
   localparam int PriceOutBits = 40;
   localparam int CountBits = 10;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_DELETED  = 3'd2,
      ST_IGNORED  = 3'd3,
      ST_DROPPED  = 3'd4,
      ST_CLEARED  = 3'd5
   } status_type;

   typedef enum logic {
      FN_LEVEL = 1'b0,
      FN_CLEAR = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_INSERT = 2'd3
   } cmd_type;

   typedef struct packed {
      logic        func;
      logic        book_side;
      logic [39:0] price;
      logic [47:0] volume;
      logic [15:0] order_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [39:0] best_bid;
      logic [39:0] best_ask;
      logic [39:0] mid_px;
      logic [9:0]  bid_levels;
      logic [9:0]  ask_levels;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/plob_cell.sv
// One level cell of a sorted chain: holds a level and reacts to broadcast commands.
`default_nettype none
module plob_cell
   import plob_pkg::*;
#(
   parameter int PriceBits = PriceBitsDefault,
   parameter int VolumeBits = VolumeBitsDefault
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    bid,
   input  wire                    clear,
   input  wire                    cmd_valid,
   input  wire cmd_type           cmd,
   input  wire [PriceBits-1:0]    price,
   input  wire [VolumeBits-1:0]   volume,
   input  wire [OrderBits-1:0]    orders,
   // left neighbor (better side)
   input  wire                    left_occ,
   input  wire                    left_better,
   input  wire [PriceBits-1:0]    left_price,
   input  wire [VolumeBits-1:0]   left_volume,
   input  wire [OrderBits-1:0]    left_orders,
   // right neighbor (worse side)
   input  wire                    right_occ,
   input  wire [PriceBits-1:0]    right_price,
   input  wire [VolumeBits-1:0]   right_volume,
   input  wire [OrderBits-1:0]    right_orders,
   output logic                   occ,
   output logic                   better,
   output logic                   match,
   output logic [PriceBits-1:0]   price_q,
   output logic [VolumeBits-1:0]  volume_q,
   output logic [OrderBits-1:0]   orders_q
);

   logic                  occ_ff, occ_in;
   logic [PriceBits-1:0]  price_ff, price_in;
   logic [VolumeBits-1:0] volume_ff, volume_in;
   logic [OrderBits-1:0]  orders_ff, orders_in;

   // left_better high means every cell to the left ranks strictly better
   assign better = occ_ff && (bid ? (price_ff > price) : (price_ff < price));
   assign match = occ_ff && (price_ff == price);

   always_comb begin
      occ_in = occ_ff;
      price_in = price_ff;
      volume_in = volume_ff;
      orders_in = orders_ff;
      if (clear) begin
         occ_in = 1'b0;
      end else if (cmd_valid) begin
         unique case (cmd)
            CMD_UPDATE: begin
               if (match) begin
                  volume_in = volume;
                  orders_in = orders;
               end
            end
            CMD_DELETE: begin
               // cells at or beyond the match position pull from the right
               if (!better) begin
                  occ_in = right_occ;
                  price_in = right_price;
                  volume_in = right_volume;
                  orders_in = right_orders;
               end
            end
            CMD_INSERT: begin
               if (!better) begin
                  if (left_better) begin
                     occ_in = 1'b1;
                     price_in = price;
                     volume_in = volume;
                     orders_in = orders;
                  end else begin
                     occ_in = left_occ;
                     price_in = left_price;
                     volume_in = left_volume;
                     orders_in = left_orders;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      price_ff <= price_in;
      volume_ff <= volume_in;
      orders_ff <= orders_in;
   end

   assign occ = occ_ff;
   assign price_q = price_ff;
   assign volume_q = volume_ff;
   assign orders_q = orders_ff;

endmodule
`default_nettype wire

FILE: rtl/core/plob_side.sv
// One side of the book: a chain of level cells plus match and full/top outputs.
`default_nettype none
module plob_side
   import plob_pkg::*;
#(
   parameter int Levels = LevelsDefault,
   parameter int PriceBits = PriceBitsDefault,
   parameter int VolumeBits = VolumeBitsDefault
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   bid,
   input  wire                   clear,
   input  wire                   cmd_valid,
   input  wire cmd_type          cmd,
   input  wire [PriceBits-1:0]   price,
   input  wire [VolumeBits-1:0]  volume,
   input  wire [OrderBits-1:0]   orders,
   output logic                  any_match,
   output logic                  last_better,
   output logic                  full,
   output logic                  top_occ,
   output logic [PriceBits-1:0]  top_price
);

   logic [Levels-1:0]     occ, better, match;
   logic [PriceBits-1:0]  px_q [Levels];
   logic [VolumeBits-1:0] vol_q [Levels];
   logic [OrderBits-1:0]  ord_q [Levels];

   for (genvar g = 0; g < Levels; g++) begin : g_cell
      logic                  l_occ, l_better, r_occ;
      logic [PriceBits-1:0]  l_px, r_px;
      logic [VolumeBits-1:0] l_vol, r_vol;
      logic [OrderBits-1:0]  l_ord, r_ord;
      if (g == 0) begin : g_head
         assign l_occ = 1'b0;
         assign l_better = 1'b1;
         assign l_px = '0;
         assign l_vol = '0;
         assign l_ord = '0;
      end else begin : g_mid
         assign l_occ = occ[g-1];
         assign l_better = better[g-1];
         assign l_px = px_q[g-1];
         assign l_vol = vol_q[g-1];
         assign l_ord = ord_q[g-1];
      end
      if (g == Levels - 1) begin : g_tail
         assign r_occ = 1'b0;
         assign r_px = '0;
         assign r_vol = '0;
         assign r_ord = '0;
      end else begin : g_body
         assign r_occ = occ[g+1];
         assign r_px = px_q[g+1];
         assign r_vol = vol_q[g+1];
         assign r_ord = ord_q[g+1];
      end
      plob_cell #(.PriceBits(PriceBits), .VolumeBits(VolumeBits)) u_cell (
         .clock(clock), .reset(reset), .bid(bid), .clear(clear),
         .cmd_valid(cmd_valid), .cmd(cmd), .price(price), .volume(volume),
         .orders(orders),
         .left_occ(l_occ), .left_better(l_better), .left_price(l_px),
         .left_volume(l_vol), .left_orders(l_ord),
         .right_occ(r_occ), .right_price(r_px), .right_volume(r_vol),
         .right_orders(r_ord),
         .occ(occ[g]), .better(better[g]), .match(match[g]),
         .price_q(px_q[g]), .volume_q(vol_q[g]), .orders_q(ord_q[g])
      );
   end

   assign any_match = |match;
   assign last_better = better[Levels-1];
   assign full = occ[Levels-1];
   assign top_occ = occ[0];
   assign top_price = px_q[0];

endmodule
`default_nettype wire

FILE: rtl/core/price_level_order_book.sv
// Top level of the price level order book: two cell chains and result logic.
//
//   channel  dir  ports          payload
//   request  in   req_valid/stall  req_type
//   response out  rsp_valid/stall  rsp_type
//
// An item passes through the block in order: the request is registered, then
// every cell of the chosen side compares against it and shifts or overwrites
// (a clear item empties both sides instead), then the response register loads
// from the updated chains. No new item is taken before that response has loaded,
// and only while the response register is empty or transferring. Reset empties both chains at once.
// A stalled response holds its payload and blocks further requests.
`default_nettype none
module price_level_order_book
   import plob_pkg::*;
#(
   parameter int LevelsPerSide = LevelsDefault,
   parameter int PriceBits = PriceBitsDefault,
   parameter int VolumeBits = VolumeBitsDefault
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CntW = $clog2(LevelsPerSide + 1);

   logic busy_ff, busy_in;
   logic rsp_valid_ff, rsp_valid_in;
   req_type item_ff, item_in;
   logic [CntW-1:0] bid_cnt_ff, bid_cnt_in, ask_cnt_ff, ask_cnt_in;
   status_type status_ff, status_in;
   logic finish_ff, finish_in;

   logic accept, bid, clear, go, do_level;
   cmd_type cmd;
   logic [PriceBits-1:0] px;
   logic [VolumeBits-1:0] vol;
   logic b_match, b_last, b_full, b_top, a_match, a_last, a_full, a_top;
   logic [PriceBits-1:0] b_price, a_price;
   logic s_match, s_last, s_full, vol_zero;
   logic [PriceOutBits-1:0] bb, ba, mid;
   logic [PriceOutBits:0] sum;

   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;

   assign bid = item_ff.book_side;
   assign px = PriceBits'(item_ff.price);
   assign vol = VolumeBits'(item_ff.volume);
   assign vol_zero = (vol == '0);
   assign s_match = bid ? b_match : a_match;
   assign s_last = bid ? b_last : a_last;
   assign s_full = bid ? b_full : a_full;
   assign go = busy_ff && !finish_ff;
   assign clear = go && (item_ff.func == FN_CLEAR);
   assign do_level = go && (item_ff.func == FN_LEVEL);

   always_comb begin
      cmd = CMD_NONE;
      status_in = status_ff;
      bid_cnt_in = bid_cnt_ff;
      ask_cnt_in = ask_cnt_ff;
      if (clear) begin
         status_in = ST_CLEARED;
         bid_cnt_in = '0;
         ask_cnt_in = '0;
      end else if (do_level) begin
         priority if (s_match && vol_zero) begin
            cmd = CMD_DELETE;
            status_in = ST_DELETED;
            if (bid) bid_cnt_in = bid_cnt_ff - CntW'(1);
            else ask_cnt_in = ask_cnt_ff - CntW'(1);
         end else if (s_match) begin
            cmd = CMD_UPDATE;
            status_in = ST_UPDATED;
         end else if (vol_zero) begin
            status_in = ST_IGNORED;
         end else if (s_full && s_last) begin
            status_in = ST_DROPPED;
         end else begin
            cmd = CMD_INSERT;
            status_in = ST_INSERTED;
            if (!s_full) begin
               if (bid) bid_cnt_in = bid_cnt_ff + CntW'(1);
               else ask_cnt_in = ask_cnt_ff + CntW'(1);
            end
         end
      end
   end

   plob_side #(.Levels(LevelsPerSide), .PriceBits(PriceBits), .VolumeBits(VolumeBits))
   u_bid (
      .clock(clock), .reset(reset), .bid(1'b1), .clear(clear),
      .cmd_valid(do_level && bid), .cmd(cmd), .price(px), .volume(vol),
      .orders(item_ff.order_count),
      .any_match(b_match), .last_better(b_last), .full(b_full),
      .top_occ(b_top), .top_price(b_price)
   );

   plob_side #(.Levels(LevelsPerSide), .PriceBits(PriceBits), .VolumeBits(VolumeBits))
   u_ask (
      .clock(clock), .reset(reset), .bid(1'b0), .clear(clear),
      .cmd_valid(do_level && !bid), .cmd(cmd), .price(px), .volume(vol),
      .orders(item_ff.order_count),
      .any_match(a_match), .last_better(a_last), .full(a_full),
      .top_occ(a_top), .top_price(a_price)
   );

   always_comb begin
      busy_in = busy_ff;
      finish_in = 1'b0;
      item_in = item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         busy_in = 1'b1;
         item_in = req_data;
      end else if (go) begin
         finish_in = 1'b1;
      end else if (busy_ff && finish_ff) begin
         busy_in = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   assign bb = b_top ? PriceOutBits'(b_price) : '0;
   assign ba = a_top ? PriceOutBits'(a_price) : '0;
   assign sum = {1'b0, bb} + {1'b0, ba};
   assign mid = (b_top && a_top) ? sum[PriceOutBits:1] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         finish_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bid_cnt_ff <= '0;
         ask_cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         finish_ff <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
         bid_cnt_ff <= bid_cnt_in;
         ask_cnt_ff <= ask_cnt_in;
      end
      item_ff <= item_in;
      status_ff <= status_in;
      if (busy_ff && finish_ff) begin
         rsp_data.status <= status_ff;
         rsp_data.best_bid <= bb;
         rsp_data.best_ask <= ba;
         rsp_data.mid_px <= mid;
         rsp_data.bid_levels <= CountBits'(bid_cnt_ff);
         rsp_data.ask_levels <= CountBits'(ask_cnt_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire
